// ===== hw/rtl/cofe_pkg.sv =====
// shared types and codes for the clause occurrence flip engine
// no dependencies
package cofe_pkg;

	localparam logic [2:0] REQ_LOAD  = 3'd0;
	localparam logic [2:0] REQ_SETC  = 3'd1;
	localparam logic [2:0] REQ_BREAK = 3'd2;
	localparam logic [2:0] REQ_FLIP  = 3'd3;
	localparam logic [2:0] REQ_READ  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_UNDER = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [0:0] CFG_CLAUSE_LENGTH = 1'd0;
	localparam logic [0:0] CFG_CLAUSE_COUNT  = 1'd1;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [11:0] literal;
		logic [12:0]        index;
		logic [3:0]         true_count;
	} req_t;

	typedef struct packed {
		logic [12:0] result_value;
		logic [1:0]  status;
	} rsp_t;

endpackage

// ===== hw/rtl/cofe_clear.sv =====
// reset clearing sweep for the per-entry count memories
// depends on no other file; parameters give the address width and the last address
module cofe_clear #(
	parameter int AW = 13,
	parameter int LAST = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	output logic          busy,
	output logic [AW-1:0] addr
);
	logic [AW-1:0] cnt_q;
	logic          busy_q;

	// walk every address once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q == AW'(LAST)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign busy = busy_q;
	assign addr = cnt_q;
endmodule

// ===== hw/rtl/clause_occurrence_flip_engine.sv =====
// Clause occurrence and flip engine: top level with sequencer and memories.
// Set count and rejected requests answer from idle; load reads the list length and writes;
// read fetches the unsat entry; break and flip walk the occurrences, flip rescans the clauses.
// One item at a time; input stalls until the result transfers, and the next item can be
// taken in the cycle the result transfers. After reset a clearing sweep over addresses
// 0 to max(MAX_CLAUSES, MAX_VARS) runs; no item is taken until it ends.
module clause_occurrence_flip_engine
	import cofe_pkg::*;
#(
	parameter int MAX_VARS    = 1024,
	parameter int MAX_CLAUSES = 4096,
	parameter int MAX_OCC     = 64,
	parameter int MAX_K       = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_wdata
);
	localparam int VW  = $clog2(MAX_VARS + 1);
	localparam int CW  = $clog2(MAX_CLAUSES + 2);
	localparam int UW  = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
	localparam int OW  = $clog2(MAX_OCC + 1);
	localparam int OIW = (MAX_OCC > 1) ? $clog2(MAX_OCC) : 1;
	localparam int KW  = $clog2(MAX_K + 1);
	localparam int CLW = (CW > VW) ? CW : VW;
	localparam int CLEAR_LAST = (MAX_CLAUSES > MAX_VARS) ? MAX_CLAUSES : MAX_VARS;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_OCCRD = 4'd2;
	localparam logic [3:0] S_TCRD  = 4'd3;
	localparam logic [3:0] S_TCUSE = 4'd4;
	localparam logic [3:0] S_SCAN  = 4'd5;
	localparam logic [3:0] S_SCANW = 4'd6;
	localparam logic [3:0] S_DONE  = 4'd7;
	localparam logic [3:0] S_LENRD = 4'd8;
	localparam logic [3:0] S_READ  = 4'd9;
	localparam logic [3:0] S_LOAD  = 4'd10;

	// memories
	logic [OW-1:0] len_mem [MAX_VARS+1];
	logic [CW:0]   occ_mem [(MAX_VARS+1)*MAX_OCC];
	logic [3:0]    tc_mem  [MAX_CLAUSES+1];
	logic [CW-1:0] uns_mem [MAX_CLAUSES];

	logic [3:0]    clen_q;
	logic [12:0]   ccount_q;
	logic [3:0]    state_q;
	logic [2:0]    req_q;
	logic          neg_q;
	logic [VW-1:0] var_q;
	logic          var_bad_q;
	logic          pad_q;
	logic [CW-1:0] idx_q;
	logic [OW-1:0] i_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] last_q;
	logic [CW:0]   occ_rd_q;
	logic [3:0]    tc_rd_q;
	logic [OW-1:0] len_rd_q;
	logic [CW-1:0] uns_rd_q;
	logic [12:0]   res_q;
	logic          under_q, over_q;
	logic [2:0]    slot_q;
	logic [CW-1:0] lclause_q;
	logic [CW-1:0] utot_q;
	logic          ovalid_q;
	rsp_t          odata_q;

	logic          clr_busy;
	logic [CLW-1:0] clr_addr;

	cofe_clear #(.AW(CLW), .LAST(CLEAR_LAST)) u_clear (
		.clk(clk), .arst_n(arst_n), .busy(clr_busy), .addr(clr_addr)
	);

	// decode of the incoming literal
	logic [11:0] raw_mag;
	logic        in_neg;
	logic        var_bad;
	assign in_neg  = in_data.literal[11];
	assign raw_mag = in_neg ? (12'd0 - in_data.literal) : in_data.literal;
	assign var_bad = (raw_mag == 12'd0) || ({20'd0, raw_mag} > 32'(MAX_VARS));

	logic [3:0] eff_k;
	always_comb begin
		if (clen_q == 4'd0) eff_k = 4'd1;
		else if ({28'd0, clen_q} > 32'(MAX_K)) eff_k = 4'(MAX_K);
		else eff_k = clen_q;
	end

	logic idle;
	assign idle     = (state_q == S_IDLE) && !clr_busy && !(ovalid_q && out_stall);
	assign in_stall = !idle;

	logic accept;
	assign accept = in_valid && idle;

	// occurrence list length of the current variable, valid in the state after S_LENRD
	logic len_ok;
	assign len_ok = ({{(32-OW){1'b0}}, len_rd_q} < 32'(MAX_OCC));

	logic [$clog2((MAX_VARS+1)*MAX_OCC)-1:0] occ_addr;
	logic [OIW-1:0] i_idx;
	assign i_idx    = i_q[OIW-1:0];
	assign occ_addr = $bits(occ_addr)'(var_q * MAX_OCC) + $bits(occ_addr)'(i_idx);
	logic [OIW-1:0] n_idx;
	assign n_idx = len_rd_q[OIW-1:0];
	logic [$clog2((MAX_VARS+1)*MAX_OCC)-1:0] occ_waddr;
	assign occ_waddr = $bits(occ_addr)'(var_q * MAX_OCC) + $bits(occ_addr)'(n_idx);

	logic [CW-1:0] occ_c;
	logic          occ_n;
	assign occ_c = occ_rd_q[CW-1:0];
	assign occ_n = occ_rd_q[CW];

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clen_q   <= 4'd3;
			ccount_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLAUSE_LENGTH: clen_q   <= cfg_wdata[3:0];
				CFG_CLAUSE_COUNT:  ccount_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			if ({{(32-CLW){1'b0}}, clr_addr} <= 32'(MAX_VARS))
				len_mem[VW'(clr_addr)] <= '0;
			if ({{(32-CLW){1'b0}}, clr_addr} <= 32'(MAX_CLAUSES))
				tc_mem[CW'(clr_addr)] <= '0;
		end else begin
			if (state_q == S_LOAD && req_q == REQ_LOAD && !var_bad_q && len_ok)
				len_mem[var_q] <= len_rd_q + 1'b1;
			if (state_q == S_LOAD && req_q == REQ_LOAD && !var_bad_q && len_ok)
				occ_mem[occ_waddr] <= {neg_q, lclause_q};
			if (state_q == S_IDLE && accept && in_data.req_type == REQ_SETC &&
			    in_data.index != 13'd0 && {19'd0, in_data.index} <= 32'(MAX_CLAUSES) &&
			    {28'd0, in_data.true_count} <= 32'(MAX_K))
				tc_mem[CW'(in_data.index)] <= in_data.true_count;
			if (state_q == S_TCUSE && req_q == REQ_FLIP) begin
				if (occ_n == neg_q) begin
					if (tc_rd_q != 4'd0) tc_mem[occ_c] <= tc_rd_q - 1'b1;
				end else if (tc_rd_q != 4'd15) begin
					tc_mem[occ_c] <= tc_rd_q + 1'b1;
				end
			end
			if (state_q == S_SCANW && tc_rd_q == 4'd0)
				uns_mem[UW'(utot_q)] <= scan_q;
		end
		len_rd_q <= len_mem[var_q];
		occ_rd_q <= occ_mem[occ_addr];
		tc_rd_q  <= tc_mem[(state_q == S_SCAN) ? scan_q : occ_c];
		uns_rd_q <= uns_mem[UW'(idx_q)];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ovalid_q  <= 1'b0;
			slot_q    <= '0;
			lclause_q <= CW'(1);
			utot_q    <= '0;
			req_q     <= '0;
			var_bad_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					req_q     <= in_data.req_type;
					neg_q     <= in_neg;
					var_q     <= VW'(raw_mag);
					var_bad_q <= var_bad;
					pad_q     <= (raw_mag == 12'd0);
					idx_q     <= CW'(in_data.index);
					i_q       <= '0;
					res_q     <= '0;
					under_q   <= 1'b0;
					over_q    <= 1'b0;
					unique case (in_data.req_type)
						REQ_LOAD: begin
							if ({{(32-CW){1'b0}}, lclause_q} > 32'(MAX_CLAUSES)) begin
								ovalid_q <= 1'b1;
								odata_q  <= '{result_value: '0, status: ST_RANGE};
							end else begin
								state_q <= S_LENRD;
							end
						end
						REQ_SETC: begin
							ovalid_q <= 1'b1;
							odata_q.result_value <= '0;
							odata_q.status <= (in_data.index == 13'd0 ||
								{19'd0, in_data.index} > 32'(MAX_CLAUSES) ||
								{28'd0, in_data.true_count} > 32'(MAX_K))
								? ST_RANGE : ST_OK;
						end
						REQ_BREAK, REQ_FLIP: begin
							if (var_bad) begin
								ovalid_q <= 1'b1;
								odata_q  <= '{result_value: '0, status: ST_RANGE};
							end else begin
								state_q <= S_LENRD;
							end
						end
						REQ_READ: begin
							if ({{(32-CW){1'b0}}, CW'(in_data.index)} < 32'(MAX_CLAUSES) &&
							    {19'd0, in_data.index} < {{(32-CW){1'b0}}, utot_q} &&
							    in_data.index[12:0] == 13'(CW'(in_data.index))) begin
								state_q <= S_READ;
							end else begin
								ovalid_q <= 1'b1;
								odata_q  <= '{result_value: '0, status: ST_RANGE};
							end
						end
						default: begin
							ovalid_q <= 1'b1;
							odata_q  <= '{result_value: '0, status: ST_RANGE};
						end
					endcase
				end
				S_LENRD: begin
					state_q <= (req_q == REQ_LOAD) ? S_LOAD : S_OCCRD;
				end
				S_LOAD: begin
					// slot advance and status
					ovalid_q <= 1'b1;
					odata_q.result_value <= '0;
					if (pad_q) odata_q.status <= ST_OK;
					else if (var_bad_q) odata_q.status <= ST_RANGE;
					else if (!len_ok) odata_q.status <= ST_FULL;
					else odata_q.status <= ST_OK;
					if (4'(slot_q) + 4'd1 >= eff_k) begin
						slot_q    <= '0;
						lclause_q <= lclause_q + 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_OCCRD: begin
					if (i_q == len_rd_q) begin
						if (req_q == REQ_BREAK) begin
							state_q <= S_DONE;
						end else begin
							scan_q <= CW'(1);
							utot_q <= '0;
							if ({19'd0, ccount_q} > 32'(MAX_CLAUSES)) begin
								last_q <= CW'(MAX_CLAUSES);
								over_q <= 1'b1;
							end else begin
								last_q <= CW'(ccount_q);
							end
							state_q <= S_SCAN;
						end
					end else begin
						state_q <= S_TCRD;
					end
				end
				S_TCRD: state_q <= S_TCUSE;
				S_TCUSE: begin
					if (req_q == REQ_BREAK) begin
						if (occ_n == neg_q && tc_rd_q == 4'd1) res_q <= res_q + 1'b1;
					end else if (occ_n == neg_q) begin
						if (tc_rd_q == 4'd0) under_q <= 1'b1;
					end else if (tc_rd_q == 4'd15) begin
						over_q <= 1'b1;
					end
					i_q     <= i_q + 1'b1;
					state_q <= S_OCCRD;
				end
				S_SCAN: begin
					if ({1'b0, scan_q} > {1'b0, last_q}) begin
						res_q   <= 13'(utot_q);
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCANW;
					end
				end
				S_SCANW: begin
					if (tc_rd_q == 4'd0) utot_q <= utot_q + 1'b1;
					scan_q  <= scan_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_DONE: begin
					ovalid_q <= 1'b1;
					odata_q.result_value <= res_q;
					odata_q.status <= under_q ? ST_UNDER : (over_q ? ST_RANGE : ST_OK);
					state_q <= S_IDLE;
				end
				S_READ: state_q <= S_CLEAR;
				S_CLEAR: begin
					ovalid_q <= 1'b1;
					odata_q  <= '{result_value: 13'(uns_rd_q), status: ST_OK};
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall) else $error("accept while busy");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !out_valid) else $error("result during clearing");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");
endmodule

// ===== dv/clause_occurrence_flip_engine_tb.sv =====
// testbench for the clause occurrence flip engine: directed and random requests,
// every result checked against an in-bench prediction of occurrence lists and counts
// depends on cofe_pkg and clause_occurrence_flip_engine
`timescale 1ns / 1ps

module clause_occurrence_flip_engine_tb;
	import cofe_pkg::*;

	localparam int N_VARS    = 1024;
	localparam int N_CLAUSES = 4096;
	localparam int N_OCC     = 64;
	localparam int N_K       = 8;

	// prediction of occurrence lists, clause counts and the unsat list
	class flip_board;
		int unsigned clen;
		int unsigned ccount;
		int unsigned occ_len [N_VARS+1];
		logic [12:0] occ_clause [N_VARS+1][N_OCC];
		bit          occ_neg [N_VARS+1][N_OCC];
		int unsigned true_cnt [N_CLAUSES+1];
		logic [12:0] unsat [N_CLAUSES];
		int unsigned slot;
		int unsigned load_clause;
		int unsigned unsat_total;
		rsp_t        pending [$];
		int          errors;

		function new();
			clen = 3;
			ccount = 0;
			foreach (occ_len[i]) occ_len[i] = 0;
			foreach (true_cnt[i]) true_cnt[i] = 0;
			slot = 0;
			load_clause = 1;
			unsat_total = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [0:0] idx, logic [12:0] v);
			if (idx == CFG_CLAUSE_LENGTH) clen = v[3:0];
			else ccount = v;
		endfunction

		function int unsigned eff_k();
			if (clen == 0) return 1;
			if (clen > N_K) return N_K;
			return clen;
		endfunction

		// work out the response of one accepted transfer
		function void note(req_t r);
			logic [11:0] raw;
			bit          neg;
			int unsigned v, n, c, last;
			bit          under, over;
			rsp_t        e;
			raw = r.literal;
			neg = raw[11];
			v = neg ? (13'h1000 - raw) : raw;
			e = '0;
			e.status = ST_OK;
			case (r.req_type)
				REQ_LOAD: begin
					if (load_clause > N_CLAUSES) e.status = ST_RANGE;
					else begin
						if (v != 0) begin
							if (v > N_VARS) e.status = ST_RANGE;
							else if (occ_len[v] >= N_OCC) e.status = ST_FULL;
							else begin
								occ_clause[v][occ_len[v]] = load_clause;
								occ_neg[v][occ_len[v]] = neg;
								occ_len[v]++;
							end
						end
						if (slot + 1 >= eff_k()) begin
							slot = 0;
							load_clause++;
						end else slot++;
					end
				end
				REQ_SETC: begin
					if (r.index == 0 || r.index > N_CLAUSES || r.true_count > N_K)
						e.status = ST_RANGE;
					else true_cnt[r.index] = r.true_count;
				end
				REQ_BREAK, REQ_FLIP: begin
					if (v == 0 || v > N_VARS) e.status = ST_RANGE;
					else if (r.req_type == REQ_BREAK) begin
						n = 0;
						for (int i = 0; i < occ_len[v]; i++)
							if (occ_neg[v][i] == neg && true_cnt[occ_clause[v][i]] == 1) n++;
						e.result_value = n;
					end else begin
						under = 0;
						over = 0;
						for (int i = 0; i < occ_len[v]; i++) begin
							c = occ_clause[v][i];
							if (occ_neg[v][i] == neg) begin
								if (true_cnt[c] == 0) under = 1;
								else true_cnt[c]--;
							end else begin
								if (true_cnt[c] >= 15) over = 1;
								else true_cnt[c]++;
							end
						end
						last = ccount;
						if (last > N_CLAUSES) begin
							last = N_CLAUSES;
							over = 1;
						end
						unsat_total = 0;
						for (int i = 1; i <= last; i++)
							if (true_cnt[i] == 0) begin
								unsat[unsat_total] = i;
								unsat_total++;
							end
						e.result_value = unsat_total;
						if (under) e.status = ST_UNDER;
						else if (over) e.status = ST_RANGE;
					end
				end
				REQ_READ: begin
					if (r.index < unsat_total && r.index < N_CLAUSES)
						e.result_value = unsat[r.index];
					else e.status = ST_RANGE;
				end
				default: e.status = ST_RANGE;
			endcase
			pending.push_back(e);
		endfunction

		// compare one response transfer with the oldest prediction
		function void check(rsp_t got);
			rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response value %0d status %0d", $time,
					got.result_value, got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.result_value !== e.result_value) begin
				$display("%0t: result_value expected %0d actual %0d", $time,
					e.result_value, got.result_value);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	req_t        in_data;
	logic        out_valid;
	logic        out_stall;
	rsp_t        out_data;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [12:0] cfg_wdata;

	flip_board board;
	int        send_idle;
	int        recv_stall;
	int        hold_left;

	clause_occurrence_flip_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// response side: check accepted transfers, stall at random or hold off
	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) board.check(out_data);
			if (hold_left > 0) begin
				out_stall <= 1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall);
			end
		end
	end

	// run limit
	initial begin
		#40_000_000;
		$display("clause_occurrence_flip_engine test failed");
		$finish;
	end

	task automatic send(input logic [2:0] rt, input int lit, input int idx, input int tc);
		req_t r;
		r.req_type = rt;
		r.literal = 12'(lit);
		r.index = 13'(idx);
		r.true_count = 4'(tc);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		board.note(r);
	endtask

	// drop valid and let every outstanding response drain
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input int v);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= 13'(v);
		@(posedge clk);
		cfg_we <= 0;
		board.write_reg(idx, 13'(v));
	endtask

	function automatic int rand_lit();
		int p;
		p = $urandom_range(0, 99);
		if (p < 6) return 0;
		if (p < 10) return $urandom_range(0, 4095);
		return $urandom_range(0, 1) ? $urandom_range(1, 40) : -$urandom_range(1, 40);
	endfunction

	// one random request, mostly well formed
	task automatic random_item();
		int p;
		p = $urandom_range(0, 99);
		if (p < 35) send(REQ_LOAD, rand_lit(), $urandom_range(0, 8191), $urandom_range(0, 15));
		else if (p < 50) begin
			if ($urandom_range(0, 19) == 0)
				send(REQ_SETC, 0, $urandom_range(0, 8191), $urandom_range(0, 15));
			else send(REQ_SETC, 0, $urandom_range(1, board.ccount + 2), $urandom_range(0, 3));
		end
		else if (p < 65) send(REQ_BREAK, rand_lit(), 0, 0);
		else if (p < 80) send(REQ_FLIP, rand_lit(), 0, 0);
		else if (p < 95) begin
			if (board.unsat_total > 0 && $urandom_range(0, 9) != 0)
				send(REQ_READ, 0, $urandom_range(0, board.unsat_total - 1), 0);
			else send(REQ_READ, 0, $urandom_range(0, 8191), 0);
		end
		else send(3'($urandom_range(5, 7)), rand_lit(), $urandom_range(0, 8191), 0);
	endtask

	initial begin
		int clens [4];
		board = new();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		send_idle = 0;
		recv_stall = 0;
		hold_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: loads with padding and out-of-range variables, default k
		send(REQ_LOAD, 5, 0, 0);
		send(REQ_LOAD, -7, 0, 0);
		send(REQ_LOAD, 0, 0, 0);
		send(REQ_LOAD, 1024, 0, 0);
		send(REQ_LOAD, -1024, 0, 0);
		send(REQ_LOAD, 1025, 0, 0);
		send(REQ_LOAD, -2048, 0, 0);
		send(REQ_LOAD, 2047, 0, 0);
		send(REQ_SETC, 0, 1, 1);
		send(REQ_SETC, 0, 2, 8);
		send(REQ_SETC, 0, 4096, 8);
		send(REQ_SETC, 0, 0, 1);
		send(REQ_SETC, 0, 4097, 1);
		send(REQ_SETC, 0, 3, 9);
		send(REQ_BREAK, 5, 0, 0);
		send(REQ_BREAK, -5, 0, 0);
		send(REQ_BREAK, 0, 0, 0);
		send(REQ_BREAK, 1025, 0, 0);
		write_reg(CFG_CLAUSE_COUNT, 3);
		// flip clears clause one, then a second flip underflows
		send(REQ_FLIP, 5, 0, 0);
		send(REQ_FLIP, 5, 0, 0);
		send(REQ_FLIP, 0, 0, 0);
		send(REQ_READ, 0, 0, 0);
		send(REQ_READ, 0, board.unsat_total, 0);
		send(REQ_READ, 0, 8191, 0);
		send(3'd5, 1, 1, 1);
		send(3'd6, 0, 0, 0);
		send(3'd7, -1, 8191, 15);
		// keep raising clause one through the opposite sign
		for (int i = 0; i < 9; i++) send(REQ_FLIP, 7, 0, 0);
		write_reg(CFG_CLAUSE_COUNT, 0);
		send(REQ_FLIP, 7, 0, 0);

		// random phases with different idling and clause lengths
		clens = '{1, 8, 0, 15};
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_CLAUSE_LENGTH, clens[ph]);
			write_reg(CFG_CLAUSE_COUNT,
				(board.load_clause + 4 > 64) ? 64 : board.load_clause + 4);
			case (ph)
				0: begin send_idle = 0; recv_stall = 0; hold_left = 400; end
				1: begin send_idle = 57; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 57; end
				default: begin send_idle = 9; recv_stall = 9; end
			endcase
			for (int i = 0; i < 265; i++) begin
				if (i == 132) begin
					send_idle = 0;
					recv_stall = 0;
				end
				random_item();
			end
		end

		// full occurrence list
		send_idle = 0;
		recv_stall = 0;
		write_reg(CFG_CLAUSE_LENGTH, 8);
		while (board.occ_len[900] < N_OCC) send(REQ_LOAD, 900, 0, 0);
		send(REQ_LOAD, -900, 0, 0);
		// clause count extremes on the rescan
		write_reg(CFG_CLAUSE_COUNT, 4096);
		send(REQ_SETC, 0, 4096, 0);
		send(REQ_FLIP, -900, 0, 0);
		send(REQ_READ, 0, board.unsat_total - 1, 0);
		write_reg(CFG_CLAUSE_COUNT, 8191);
		send(REQ_FLIP, 900, 0, 0);
		send(REQ_READ, 0, 0, 0);

		drain();
		repeat (50) @(posedge clk);
		if (board.errors == 0) $display("clause_occurrence_flip_engine test passed");
		else $display("clause_occurrence_flip_engine test failed");
		$finish;
	end

endmodule
